// File: rtl/ffea_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first-fit extent allocator.
// No dependencies.
package ffea_pkg;
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 24;
    localparam int RSIZE_W   = 25;
    localparam int NPG_W     = 13;
    localparam int FCNT_W    = 7;
    localparam int STAT_W    = 32;
    localparam int HDR_BYTES = 8;
    localparam int MIN_LEFT  = 16;
    localparam int DEF_MAX_EXTENTS = 64;
    localparam int DEF_PAGE_BYTES  = 4096;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } t_extent;
endpackage

// File: rtl/ffea_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ffea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/first_fit_extent_allocator_top.sv
`timescale 1ns / 1ps
// First-fit extent allocator: sequencer around the extent table RAM.
// Depends on ffea_pkg and ffea_ram.
//
// One request at a time: busy is high from the accepting edge until the
// cycle of o_done. The extent table lives in a RAM with a registered read
// port, and every table step (scan, shift on drop, shift on insert) reads
// and then checks or writes one entry at a time; large requests bypass the
// table and go straight to done. o_done marks the result for one cycle and
// cannot be stalled. PAGE_BYTES must be a power of two.
module first_fit_extent_allocator_top #(
    parameter int MAX_EXTENTS = ffea_pkg::DEF_MAX_EXTENTS,
    parameter int PAGE_BYTES  = ffea_pkg::DEF_PAGE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [ffea_pkg::ADDR_W-1:0]   i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [ffea_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffea_pkg::ADDR_W-1:0]   i_free_addr,
    input  logic [ffea_pkg::RSIZE_W-1:0]  i_block_size,
    output logic                          o_done,
    output logic [ffea_pkg::ADDR_W-1:0]   o_user_addr,
    output logic [ffea_pkg::RSIZE_W-1:0]  o_recorded_size,
    output logic [ffea_pkg::NPG_W-1:0]    o_new_pages,
    output logic                          o_table_full,
    output logic [ffea_pkg::FCNT_W-1:0]   o_free_count,
    output logic [ffea_pkg::STAT_W-1:0]   o_pages_mapped,
    output logic [ffea_pkg::STAT_W-1:0]   o_pages_unmapped,
    output logic [ffea_pkg::STAT_W-1:0]   o_alloc_count,
    output logic [ffea_pkg::STAT_W-1:0]   o_free_ops
);
    import ffea_pkg::*;

    localparam int IW  = $clog2(MAX_EXTENTS);
    localparam int CW  = $clog2(MAX_EXTENTS + 1);
    localparam int PB  = $clog2(PAGE_BYTES);
    localparam int NW  = RSIZE_W + 1;
    localparam int EW  = $bits(t_extent);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_A_RD   = 4'd1;
    localparam logic [3:0] ST_A_CK   = 4'd2;
    localparam logic [3:0] ST_MISS   = 4'd3;
    localparam logic [3:0] ST_D_RD   = 4'd4;
    localparam logic [3:0] ST_D_WR   = 4'd5;
    localparam logic [3:0] ST_LEFT   = 4'd6;
    localparam logic [3:0] ST_P_RD   = 4'd7;
    localparam logic [3:0] ST_P_CK   = 4'd8;
    localparam logic [3:0] ST_P_DEC  = 4'd9;
    localparam logic [3:0] ST_U_RD   = 4'd10;
    localparam logic [3:0] ST_U_WR   = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
    localparam logic [RSIZE_W-1:0] PAGE_R = RSIZE_W'(PAGE_BYTES);

    logic [3:0]          r_state;
    logic [3:0]          r_ret;
    logic                r_op;
    logic [RSIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]   r_block;
    logic [SIZE_W-1:0]   r_left;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_k;
    logic [CW-1:0]       r_cnt;
    logic [ADDR_W-1:0]   r_s;
    logic [SIZE_W-1:0]   r_z;
    t_extent             r_prev;
    logic                r_prev_v;
    t_extent             r_cur;
    logic                r_cur_v;
    logic                r_full;
    logic [NW-1:0]       r_npages;
    logic [ADDR_W-1:0]   r_next_page;
    logic [STAT_W-1:0]   r_mapped;
    logic [STAT_W-1:0]   r_unmapped;
    logic [STAT_W-1:0]   r_allocs;
    logic [STAT_W-1:0]   r_frees;

    logic                w_we;
    logic [IW-1:0]       w_waddr;
    t_extent             w_wdata;
    logic [IW-1:0]       w_raddr;
    logic [EW-1:0]       w_rdata;
    t_extent             w_rd;

    ffea_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_extent'(w_rdata);

    logic                accept;
    logic [RSIZE_W-1:0]  a_size;
    logic [NW-1:0]       a_npg;
    logic [NW-1:0]       f_npg;
    logic [RSIZE_W-1:0]  pred_sum;
    logic [SIZE_W-1:0]   pred_m;
    logic                pred_ok;
    logic [RSIZE_W-1:0]  both_sum;
    logic                both_ok;
    logic [RSIZE_W-1:0]  succ_sum;
    logic                succ_ok;
    logic [RSIZE_W-1:0]  hit_left;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       pm1;
    logic [CW-1:0]       km1;

    assign accept   = start && !busy;
    assign a_size   = RSIZE_W'(i_req_size) + RSIZE_W'(HDR_BYTES);
    assign a_npg    = (NW'(a_size) + NW'(PAGE_BYTES - 1)) >> PB;
    assign f_npg    = (NW'(i_block_size) + NW'(PAGE_BYTES - 1)) >> PB;
    assign pred_sum = RSIZE_W'(r_prev.size) + RSIZE_W'(r_z);
    assign pred_m   = pred_sum[SIZE_W-1:0];
    assign pred_ok  = r_prev_v && (r_prev.start + ADDR_W'(r_prev.size) == r_s)
                      && !pred_sum[SIZE_W];
    assign both_sum = RSIZE_W'(pred_m) + RSIZE_W'(r_cur.size);
    assign both_ok  = r_cur_v && (r_prev.start + ADDR_W'(pred_m) == r_cur.start)
                      && !both_sum[SIZE_W];
    assign succ_sum = RSIZE_W'(r_z) + RSIZE_W'(r_cur.size);
    assign succ_ok  = r_cur_v && (r_s + ADDR_W'(r_z) == r_cur.start)
                      && !succ_sum[SIZE_W];
    assign hit_left = RSIZE_W'(w_rd.size) - r_size;
    assign idx_inc  = r_idx + CW'(1);
    assign pm1      = r_idx - CW'(1);
    assign km1      = r_k - CW'(1);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IW-1:0];
        w_wdata = w_rd;
        w_raddr = r_idx[IW-1:0];
        unique case (r_state)
            ST_D_RD: w_raddr = idx_inc[IW-1:0];
            ST_D_WR: w_we = 1'b1;
            ST_P_DEC: begin
                if (pred_ok) begin
                    w_we    = 1'b1;
                    w_waddr = pm1[IW-1:0];
                    w_wdata = '{start: r_prev.start,
                                size: both_ok ? both_sum[SIZE_W-1:0] : pred_m};
                end else if (succ_ok) begin
                    w_we    = 1'b1;
                    w_wdata = '{start: r_s, size: succ_sum[SIZE_W-1:0]};
                end
            end
            ST_U_RD: begin
                w_raddr = km1[IW-1:0];
                if (r_k <= r_idx) begin
                    w_we    = 1'b1;
                    w_wdata = '{start: r_s, size: r_z};
                end
            end
            ST_U_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_DONE;
            r_cnt       <= '0;
            r_next_page <= '0;
            r_mapped    <= '0;
            r_unmapped  <= '0;
            r_allocs    <= '0;
            r_frees     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_wen) begin
                        r_next_page <= i_cfg_wdata;
                    end
                    if (accept) begin
                        r_op     <= i_func;
                        r_full   <= 1'b0;
                        r_npages <= '0;
                        r_size   <= a_size;
                        r_idx    <= '0;
                        r_prev_v <= 1'b0;
                        if (i_func == FN_ALLOC) begin
                            r_allocs <= r_allocs + STAT_W'(1);
                            if (a_size < PAGE_R) begin
                                r_state <= (r_cnt == '0) ? ST_MISS : ST_A_RD;
                            end else begin
                                r_npages    <= a_npg;
                                r_block     <= r_next_page;
                                r_next_page <= r_next_page + ADDR_W'(a_npg << PB);
                                r_mapped    <= r_mapped + STAT_W'(a_npg);
                                r_state     <= ST_DONE;
                            end
                        end else begin
                            r_frees <= r_frees + STAT_W'(1);
                            if (i_block_size < PAGE_R) begin
                                r_s     <= i_free_addr - ADDR_W'(HDR_BYTES);
                                r_z     <= i_block_size[SIZE_W-1:0];
                                r_state <= ST_P_RD;
                            end else begin
                                r_unmapped <= r_unmapped + STAT_W'(f_npg);
                                r_state    <= ST_DONE;
                            end
                        end
                    end
                end
                ST_A_RD: r_state <= ST_A_CK;
                ST_A_CK: begin
                    if (RSIZE_W'(w_rd.size) >= r_size) begin
                        r_block <= w_rd.start;
                        r_left  <= hit_left[SIZE_W-1:0];
                        r_ret   <= ST_LEFT;
                        r_state <= ST_D_RD;
                    end else if (idx_inc == r_cnt) begin
                        r_state <= ST_MISS;
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= ST_A_RD;
                    end
                end
                ST_MISS: begin
                    r_block     <= r_next_page;
                    r_next_page <= r_next_page + ADDR_W'(PAGE_BYTES);
                    r_mapped    <= r_mapped + STAT_W'(1);
                    r_npages    <= NW'(1);
                    r_left      <= SIZE_W'(PAGE_R - r_size);
                    r_state     <= ST_LEFT;
                end
                ST_D_RD: begin
                    if (idx_inc < r_cnt) begin
                        r_state <= ST_D_WR;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= r_ret;
                    end
                end
                ST_D_WR: begin
                    r_idx   <= idx_inc;
                    r_state <= ST_D_RD;
                end
                ST_LEFT: begin
                    if (r_left > SIZE_W'(MIN_LEFT)) begin
                        r_s      <= r_block + ADDR_W'(r_size);
                        r_z      <= r_left;
                        r_idx    <= '0;
                        r_prev_v <= 1'b0;
                        r_state  <= ST_P_RD;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_P_RD: begin
                    if (r_idx < r_cnt) begin
                        r_state <= ST_P_CK;
                    end else begin
                        r_cur_v <= 1'b0;
                        r_state <= ST_P_DEC;
                    end
                end
                ST_P_CK: begin
                    if (w_rd.start < r_s) begin
                        r_prev   <= w_rd;
                        r_prev_v <= 1'b1;
                        r_idx    <= idx_inc;
                        r_state  <= ST_P_RD;
                    end else begin
                        r_cur   <= w_rd;
                        r_cur_v <= 1'b1;
                        r_state <= ST_P_DEC;
                    end
                end
                ST_P_DEC: begin
                    if (pred_ok) begin
                        r_ret   <= ST_DONE;
                        r_state <= both_ok ? ST_D_RD : ST_DONE;
                    end else if (succ_ok) begin
                        r_state <= ST_DONE;
                    end else if (r_cnt >= CNT_MAX) begin
                        r_full  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= r_cnt;
                        r_state <= ST_U_RD;
                    end
                end
                ST_U_RD: begin
                    if (r_k > r_idx) begin
                        r_state <= ST_U_WR;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= ST_DONE;
                    end
                end
                ST_U_WR: begin
                    r_k     <= km1;
                    r_state <= ST_U_RD;
                end
                ST_DONE: begin
                    if (i_cfg_wen) begin
                        r_next_page <= i_cfg_wdata;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic [31:0] cnt32;
    assign cnt32 = 32'(r_cnt);

    assign busy             = (r_state != ST_IDLE);
    assign o_done           = (r_state == ST_DONE);
    assign o_user_addr      = (r_op == FN_FREE) ? '0 : r_block + ADDR_W'(HDR_BYTES);
    assign o_recorded_size  = (r_op == FN_FREE) ? '0 : r_size;
    assign o_new_pages      = r_npages[NPG_W-1:0];
    assign o_table_full     = r_full;
    assign o_free_count     = cnt32[FCNT_W-1:0];
    assign o_pages_mapped   = r_mapped;
    assign o_pages_unmapped = r_unmapped;
    assign o_alloc_count    = r_allocs;
    assign o_free_ops       = r_frees;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held longer than one cycle");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX) else $error("extent count above table depth");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("transaction accepted but not busy");
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> (r_cnt == CNT_MAX))
        else $error("table full flagged with free slots");
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !accept) |=> $stable(r_cnt))
        else $error("extent count changed while idle");
endmodule

// File: tb/sv/tb_first_fit_extent_allocator_top.sv
`timescale 1ns / 1ps
// Self-checking bench for first_fit_extent_allocator_top: directed and random
// allocate/free transactions checked against an in-bench allocator model.
// Depends on ffea_pkg and the allocator RTL.
module tb_first_fit_extent_allocator_top;
    import ffea_pkg::*;

    localparam int NEXT = DEF_MAX_EXTENTS;
    localparam int PGB  = DEF_PAGE_BYTES;
    localparam logic [23:0] SZ_MAX24 = 24'hFFFFFF;

    typedef struct packed {
        logic [ADDR_W-1:0]  user_addr;
        logic [RSIZE_W-1:0] rec_size;
        logic [NPG_W-1:0]   new_pages;
        logic               full;
        logic [FCNT_W-1:0]  fcount;
        logic [STAT_W-1:0]  mapped;
        logic [STAT_W-1:0]  unmapped;
        logic [STAT_W-1:0]  allocs;
        logic [STAT_W-1:0]  frees;
    } t_outcome;

    typedef struct {
        logic               func;
        logic [SIZE_W-1:0]  req;
        logic [ADDR_W-1:0]  faddr;
        logic [RSIZE_W-1:0] bsize;
        bit                 fixed;
        t_outcome           want;
    } t_row;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_cfg_wen = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;
    logic start = 1'b0, busy;
    logic i_func = 1'b0;
    logic [SIZE_W-1:0] i_req_size = '0;
    logic [ADDR_W-1:0] i_free_addr = '0;
    logic [RSIZE_W-1:0] i_block_size = '0;
    logic o_done, o_table_full;
    logic [ADDR_W-1:0] o_user_addr;
    logic [RSIZE_W-1:0] o_recorded_size;
    logic [NPG_W-1:0] o_new_pages;
    logic [FCNT_W-1:0] o_free_count;
    logic [STAT_W-1:0] o_pages_mapped, o_pages_unmapped, o_alloc_count, o_free_ops;

    first_fit_extent_allocator_top i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // allocator model state
    logic [31:0] ext_start [NEXT];
    logic [31:0] ext_size  [NEXT];
    int unsigned ext_cnt;
    logic [31:0] page_ptr, mapped_tot, unmapped_tot, alloc_tot, free_tot;

    t_outcome outcome_q[$];
    int unsigned mismatches = 0, n_done = 0, n_alloc_sent = 0, n_free_sent = 0;
    int unsigned n_full = 0;
    logic [31:0] live_addr[$];
    logic [24:0] live_size[$];

    function automatic void remove_extent(int unsigned idx);
        for (int unsigned k = idx; k + 1 < ext_cnt; k++) begin
            ext_start[k] = ext_start[k+1];
            ext_size[k]  = ext_size[k+1];
        end
        ext_cnt--;
    endfunction

    function automatic bit insert_extent(logic [31:0] s, logic [31:0] z);
        int unsigned p;
        p = 0;
        while (p < ext_cnt && ext_start[p] < s) p++;
        if (p > 0 && ext_start[p-1] + ext_size[p-1] == s
                && ext_size[p-1] + z <= SZ_MAX24) begin
            ext_size[p-1] += z;
            if (p < ext_cnt && ext_start[p-1] + ext_size[p-1] == ext_start[p]
                    && ext_size[p-1] + ext_size[p] <= SZ_MAX24) begin
                ext_size[p-1] += ext_size[p];
                remove_extent(p);
            end
            return 1;
        end
        if (p < ext_cnt && s + z == ext_start[p] && z + ext_size[p] <= SZ_MAX24) begin
            ext_start[p] = s;
            ext_size[p] += z;
            return 1;
        end
        if (ext_cnt >= NEXT) return 0;
        for (int unsigned k = ext_cnt; k > p; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_size[k]  = ext_size[k-1];
        end
        ext_start[p] = s;
        ext_size[p]  = z;
        ext_cnt++;
        return 1;
    endfunction

    function automatic t_outcome predict_request(logic func, logic [23:0] req,
                                                 logic [31:0] faddr, logic [24:0] bsize);
        t_outcome r;
        logic [31:0] sz, blk, left, np;
        int unsigned i;
        r = '0;
        np = 0;
        if (func == FN_ALLOC) begin
            sz = req + HDR_BYTES;
            alloc_tot++;
            if (sz < PGB) begin
                i = 0;
                while (i < ext_cnt && ext_size[i] < sz) i++;
                if (i < ext_cnt) begin
                    blk = ext_start[i];
                    left = ext_size[i] - sz;
                    remove_extent(i);
                end else begin
                    blk = page_ptr;
                    page_ptr += PGB;
                    mapped_tot++;
                    np = 1;
                    left = PGB - sz;
                end
                if (left > MIN_LEFT) r.full = !insert_extent(blk + sz, left);
            end else begin
                np = (sz + PGB - 1) / PGB;
                blk = page_ptr;
                page_ptr += np * PGB;
                mapped_tot += np;
            end
            r.user_addr = blk + HDR_BYTES;
            r.rec_size = sz[24:0];
        end else begin
            free_tot++;
            if (bsize < PGB) r.full = !insert_extent(faddr - HDR_BYTES, 32'(bsize));
            else unmapped_tot += (32'(bsize) + PGB - 1) / PGB;
        end
        r.new_pages = np[NPG_W-1:0];
        r.fcount = ext_cnt[FCNT_W-1:0];
        r.mapped = mapped_tot;
        r.unmapped = unmapped_tot;
        r.allocs = alloc_tot;
        r.frees = free_tot;
        return r;
    endfunction

    task automatic write_page_base(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_wen = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
        page_ptr = v;
    endtask

    task automatic wait_drained();
        while (outcome_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    bit no_gaps = 0;

    task automatic send_request(logic func, logic [23:0] req, logic [31:0] faddr,
                                logic [24:0] bsize);
        t_outcome w;
        while (!no_gaps && $urandom_range(99) < 18) @(negedge i_clk);
        i_func = func;
        i_req_size = req;
        i_free_addr = faddr;
        i_block_size = bsize;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        w = predict_request(func, req, faddr, bsize);
        outcome_q.push_back(w);
        if (func == FN_ALLOC) begin
            n_alloc_sent++;
            if (w.rec_size < PGB) begin
                live_addr.push_back(w.user_addr);
                live_size.push_back(w.rec_size);
            end
        end else n_free_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome got, exp_r;
        if (i_rst_n && o_done) begin
            got = '{o_user_addr, o_recorded_size, o_new_pages, o_table_full,
                    o_free_count, o_pages_mapped, o_pages_unmapped,
                    o_alloc_count, o_free_ops};
            n_done++;
            if (got.full) n_full++;
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected transaction %p", got);
            end else begin
                exp_r = outcome_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: transaction %0d exp %p got %p", n_done, exp_r, got);
                end
            end
        end
    end

    t_row dir_rows[$];

    function automatic t_outcome stats(logic [31:0] ua, logic [24:0] rs, logic [12:0] np,
                                       logic fl, logic [6:0] fc, logic [31:0] m,
                                       logic [31:0] u, logic [31:0] a, logic [31:0] f);
        t_outcome r;
        r = '{ua, rs, np, fl, fc, m, u, a, f};
        return r;
    endfunction

    initial begin
        #4000000;
        $display("first_fit_extent_allocator_top test failed");
        $finish;
    end

    initial begin
        logic [31:0] pb;
        int unsigned pick;
        ext_cnt = 0;
        page_ptr = 0;
        mapped_tot = 0; unmapped_tot = 0; alloc_tot = 0; free_tot = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: after reset page_base is 0
        dir_rows.push_back('{FN_ALLOC, 24'd8, 32'd0, 25'd0, 1'b1,
            stats(32'd8, 25'd16, 13'd1, 1'b0, 7'd1, 32'd1, 32'd0, 32'd1, 32'd0)});
        dir_rows.push_back('{FN_ALLOC, 24'hFFFFFF, 32'd0, 25'd0, 1'b1,
            stats(32'd4104, 25'h1000007, 13'd4097, 1'b0, 7'd1, 32'd4098, 32'd0,
                  32'd2, 32'd0)});
        dir_rows.push_back('{FN_ALLOC, 24'd0, 32'd0, 25'd0, 1'b0, '0});
        dir_rows.push_back('{FN_ALLOC, 24'd4087, 32'd0, 25'd0, 1'b0, '0});
        dir_rows.push_back('{FN_ALLOC, 24'd4088, 32'd0, 25'd0, 1'b0, '0});
        dir_rows.push_back('{FN_ALLOC, 24'd4072, 32'd0, 25'd0, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'd8, 25'd16, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'hFFFFFFFF, 25'd0, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'd0, 25'h1FFFFFF, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'd4, 25'd4095, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'd4, 25'd4096, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'd4099, 25'd40, 1'b0, '0});
        dir_rows.push_back('{FN_FREE, 24'd0, 32'd8, 25'd100, 1'b0, '0});
        dir_rows.push_back('{FN_ALLOC, 24'd10, 32'd0, 25'd0, 1'b0, '0});
        foreach (dir_rows[r]) begin
            send_request(dir_rows[r].func, dir_rows[r].req, dir_rows[r].faddr,
                         dir_rows[r].bsize);
            if (dir_rows[r].fixed && outcome_q[$] !== dir_rows[r].want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: directed row %0d predicted %p want %p",
                             r, outcome_q[$], dir_rows[r].want);
            end
        end

        // fill the table to full, wrap address near top
        wait_drained();
        write_page_base(32'hFFFFF000);
        for (int k = 0; k < 70; k++)
            send_request(FN_FREE, 24'd0, 32'h0010_0000 + k * 64, 25'd20);
        send_request(FN_ALLOC, 24'd100, 32'd0, 25'd0);
        send_request(FN_ALLOC, 24'd5000, 32'd0, 25'd0);

        // random phases with different page bases
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            unique case (ph)
                0: pb = 32'd0;
                1: pb = 32'hFFFFFFFF;
                default: pb = $urandom;
            endcase
            write_page_base(pb);
            no_gaps = (ph == 2);
            for (int n = 0; n < 200; n++) begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_request(FN_ALLOC, ($urandom_range(9) == 0) ? 24'($urandom)
                                 : 24'($urandom_range(4095)), 32'd0, 25'd0);
                else if (pick < 80 && live_addr.size() != 0) begin
                    pick = $urandom_range(live_addr.size() - 1);
                    send_request(FN_FREE, 24'($urandom), live_addr[pick], live_size[pick]);
                    live_addr.delete(pick);
                    live_size.delete(pick);
                end else
                    send_request(FN_FREE, 24'($urandom), $urandom,
                                 ($urandom_range(3) == 0) ? 25'($urandom)
                                 : 25'($urandom_range(4095)));
                if (n == 100) wait_drained();
            end
        end
        no_gaps = 0;

        wait_drained();
        repeat (300) @(negedge i_clk);
        $display("Covered %0d allocates and %0d frees, %0d results, %0d table-full drops.",
                 n_alloc_sent, n_free_sent, n_done, n_full);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("first_fit_extent_allocator_top test passed");
        else
            $display("first_fit_extent_allocator_top test failed");
        $finish;
    end
endmodule
